// ===== rtl/lvlp_pkg.sv =====
// Package for the label/value line parser: widths, field codes, the line
// record passed from front to back, and the value conversion helpers.
// No dependencies.
package lvlp_pkg;

  localparam int LABEL_CHARS = 8;
  localparam int VALUE_CHARS = 15;
  localparam int LLEN_W = $clog2(LABEL_CHARS + 1);
  localparam int VCNT_W = $clog2(VALUE_CHARS + 1);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [15:0] WARN_MASK = 16'h0F63;

  // Common start of the three inverter output labels.
  localparam logic [55:0] LBL_AC_PREFIX = "AC_OUT_";

  localparam logic [4:0] FC_V_C = 5'd0;
  localparam logic [4:0] FC_VPV = 5'd1;
  localparam logic [4:0] FC_PPV = 5'd2;
  localparam logic [4:0] FC_I = 5'd3;
  localparam logic [4:0] FC_H19 = 5'd4;
  localparam logic [4:0] FC_H20 = 5'd5;
  localparam logic [4:0] FC_H21 = 5'd6;
  localparam logic [4:0] FC_H22 = 5'd7;
  localparam logic [4:0] FC_H23 = 5'd8;
  localparam logic [4:0] FC_ERR = 5'd9;
  localparam logic [4:0] FC_CS_C = 5'd10;
  localparam logic [4:0] FC_V_INV = 5'd11;
  localparam logic [4:0] FC_AC_V = 5'd12;
  localparam logic [4:0] FC_AC_I = 5'd13;
  localparam logic [4:0] FC_AC_S = 5'd14;
  localparam logic [4:0] FC_WARN = 5'd15;
  localparam logic [4:0] FC_AR = 5'd16;
  localparam logic [4:0] FC_CS_I = 5'd17;
  localparam logic [4:0] FC_MODE = 5'd18;

  typedef enum logic [1:0] {
    SCAN_SKIP = 2'd0,
    SCAN_SIGN = 2'd1,
    SCAN_DIGITS = 2'd2,
    SCAN_DONE = 2'd3
  } scan_t;

  // One completed, matched line handed from the front end to the back end.
  typedef struct packed {
    logic [4:0]  code;
    logic [31:0] mag;
    logic        neg;
    logic        ovf;
  } line_t;

  // Eight characters packed, first character in the low byte.
  function automatic logic [63:0] str8(input logic [63:0] s, input int len);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < len) r[i*8 +: 8] = s[(len-1-i)*8 +: 8];
    end
    return r;
  endfunction

  function automatic logic [7:0] pack_mask(input logic [15:0] v);
    return {v[11], v[10], v[9], v[8], v[6], v[5], v[1], v[0]};
  endfunction

endpackage

// ===== rtl/lvlp_front.sv =====
// Front end of the line parser: collects the label, scans the value and
// matches the label on LF. Depends on lvlp_pkg.
module lvlp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 device_kind,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  output logic                 q_valid,
  input  logic                 q_ready,
  output lvlp_pkg::line_t      q_line
);
  import lvlp_pkg::*;

  logic                   phase_r, phase_nxt;
  logic [LABEL_CHARS-1:0][7:0] lab_r, lab_nxt;
  logic [LLEN_W-1:0]      llen_r, llen_nxt;
  logic                   ltl_r, ltl_nxt;
  logic [31:0]            mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [VCNT_W-1:0]      vcnt_r, vcnt_nxt;
  scan_t                  scan_r, scan_nxt;

  logic       take, is_digit, is_ws, hit;
  logic [4:0] code;
  logic [35:0] m10;
  logic [63:0] lab8;

  assign in_ready = q_ready;
  assign take = in_valid & in_ready;
  assign is_digit = (in_data_byte >= "0") && (in_data_byte <= "9");
  assign is_ws = (in_data_byte == " ") || (in_data_byte == CH_TAB) ||
                 (in_data_byte == 8'h0B) || (in_data_byte == 8'h0C) ||
                 (in_data_byte == 8'h0D);
  assign m10 = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0} + {28'd0, in_data_byte - 8'h30};

  always_comb begin
    lab8 = '0;
    for (int i = 0; i < 8 && i < LABEL_CHARS; i++) lab8[i*8 +: 8] = lab_r[i];
  end

  // Label lookup against the table of the selected device kind.
  always_comb begin
    hit = 1'b1;
    code = FC_V_C;
    if (ltl_r) hit = 1'b0;
    else if (!device_kind) begin
      if (llen_r == 1 && lab8 == str8("V", 1)) code = FC_V_C;
      else if (llen_r == 3 && lab8 == str8("VPV", 3)) code = FC_VPV;
      else if (llen_r == 3 && lab8 == str8("PPV", 3)) code = FC_PPV;
      else if (llen_r == 1 && lab8 == str8("I", 1)) code = FC_I;
      else if (llen_r == 3 && lab8 == str8("H19", 3)) code = FC_H19;
      else if (llen_r == 3 && lab8 == str8("H20", 3)) code = FC_H20;
      else if (llen_r == 3 && lab8 == str8("H21", 3)) code = FC_H21;
      else if (llen_r == 3 && lab8 == str8("H22", 3)) code = FC_H22;
      else if (llen_r == 3 && lab8 == str8("H23", 3)) code = FC_H23;
      else if (llen_r == 3 && lab8 == str8("ERR", 3)) code = FC_ERR;
      else if (llen_r == 2 && lab8 == str8("CS", 2)) code = FC_CS_C;
      else hit = 1'b0;
    end else begin
      if (llen_r == 1 && lab8 == str8("V", 1)) code = FC_V_INV;
      else if (llen_r == 8 && lab8 == str8({LBL_AC_PREFIX, "V"}, 8)) code = FC_AC_V;
      else if (llen_r == 8 && lab8 == str8({LBL_AC_PREFIX, "I"}, 8)) code = FC_AC_I;
      else if (llen_r == 8 && lab8 == str8({LBL_AC_PREFIX, "S"}, 8)) code = FC_AC_S;
      else if (llen_r == 4 && lab8 == str8("WARN", 4)) code = FC_WARN;
      else if (llen_r == 2 && lab8 == str8("AR", 2)) code = FC_AR;
      else if (llen_r == 2 && lab8 == str8("CS", 2)) code = FC_CS_I;
      else if (llen_r == 4 && lab8 == str8("MODE", 4)) code = FC_MODE;
      else hit = 1'b0;
    end
  end

  assign q_valid = in_valid & phase_r & (in_data_byte == CH_LF) & hit;
  assign q_line = '{code: code, mag: mag_r, neg: neg_r, ovf: ovf_r};

  always_comb begin
    phase_nxt = phase_r;
    lab_nxt = lab_r;
    llen_nxt = llen_r;
    ltl_nxt = ltl_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    ovf_nxt = ovf_r;
    vcnt_nxt = vcnt_r;
    scan_nxt = scan_r;
    if (!phase_r) begin
      if (in_data_byte == CH_TAB) begin
        phase_nxt = 1'b1;
        mag_nxt = '0;
        neg_nxt = 1'b0;
        ovf_nxt = 1'b0;
        vcnt_nxt = '0;
        scan_nxt = SCAN_SKIP;
      end else if (llen_r < LLEN_W'(LABEL_CHARS)) begin
        lab_nxt[llen_r[$clog2(LABEL_CHARS)-1:0]] = in_data_byte;
        llen_nxt = llen_r + 1'b1;
      end else begin
        ltl_nxt = 1'b1;
      end
    end else if (in_data_byte == CH_LF) begin
      phase_nxt = 1'b0;
      lab_nxt = '0;
      llen_nxt = '0;
      ltl_nxt = 1'b0;
      mag_nxt = '0;
      neg_nxt = 1'b0;
      ovf_nxt = 1'b0;
      vcnt_nxt = '0;
      scan_nxt = SCAN_SKIP;
    end else if (vcnt_r < VCNT_W'(VALUE_CHARS)) begin
      vcnt_nxt = vcnt_r + 1'b1;
      if (is_digit && (scan_r != SCAN_DONE)) begin
        scan_nxt = SCAN_DIGITS;
        if (!ovf_r) begin
          if (m10[35:32] != 4'd0) begin
            ovf_nxt = 1'b1;
            mag_nxt = '1;
          end else begin
            mag_nxt = m10[31:0];
          end
        end
      end else begin
        case (scan_r)
          SCAN_SKIP: begin
            if (is_ws) scan_nxt = SCAN_SKIP;
            else if (in_data_byte == "+") scan_nxt = SCAN_SIGN;
            else if (in_data_byte == "-") begin
              neg_nxt = 1'b1;
              scan_nxt = SCAN_SIGN;
            end else scan_nxt = SCAN_DONE;
          end
          SCAN_SIGN, SCAN_DIGITS: scan_nxt = SCAN_DONE;
          default: scan_nxt = SCAN_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      lab_r <= '0;
      llen_r <= '0;
      ltl_r <= 1'b0;
      mag_r <= '0;
      neg_r <= 1'b0;
      ovf_r <= 1'b0;
      vcnt_r <= '0;
      scan_r <= SCAN_SKIP;
    end else if (take) begin
      phase_r <= phase_nxt;
      lab_r <= lab_nxt;
      llen_r <= llen_nxt;
      ltl_r <= ltl_nxt;
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      ovf_r <= ovf_nxt;
      vcnt_r <= vcnt_nxt;
      scan_r <= scan_nxt;
    end
  end
endmodule

// ===== rtl/lvlp_queue.sv =====
// Two-entry queue of matched lines between the front and back ends.
// Depends on lvlp_pkg.
module lvlp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  lvlp_pkg::line_t wr_line,
  output logic            rd_valid,
  input  logic            rd_ready,
  output lvlp_pkg::line_t rd_line
);
  import lvlp_pkg::*;

  line_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_line = mem_r[rp_r];
  assign push = wr_valid & wr_ready;
  assign pop = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/lvlp_back.sv =====
// Back end of the line parser: converts a matched line's value by field code
// into the output register. Depends on lvlp_pkg.
module lvlp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  lvlp_pkg::line_t    q_line,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_field_code,
  output logic signed [16:0] out_field_value
);
  import lvlp_pkg::*;

  logic              vld_r;
  logic [4:0]        code_r;
  logic signed [16:0] val_r, val_nxt;
  logic [31:0]       u;
  logic [15:0]       s16, a16, q16;
  logic              sneg;
  logic [33:0]       prod;

  assign q_ready = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_field_code = code_r;
  assign out_field_value = val_r;

  always_comb begin
    if (q_line.ovf) u = '1;
    else if (q_line.neg) u = 32'd0 - q_line.mag;
    else u = q_line.mag;
    // Signed clamp to 32 bits, then low 16 bits.
    if (q_line.ovf) s16 = q_line.neg ? 16'h0000 : 16'hFFFF;
    else if (q_line.neg) s16 = q_line.mag[31] && (q_line.mag[30:0] != '0) ?
                              16'h0000 : 16'(32'd0 - q_line.mag);
    else s16 = q_line.mag[31] ? 16'hFFFF : q_line.mag[15:0];
  end

  // Divide by 10 via reciprocal multiply (exact for 16-bit operands).
  always_comb begin
    sneg = 1'b0;
    a16 = u[15:0];
    if (q_line.code == FC_I) begin
      sneg = s16[15];
      a16 = sneg ? 16'(16'd0 - s16) : s16;
    end
    prod = {18'd0, a16} * 34'd52429;
    q16 = prod[34-1:19] > 15'h7FFF ? 16'hFFFF : {1'b0, prod[33:19]};
  end

  always_comb begin
    case (q_line.code)
      FC_VPV: val_nxt = {1'b0, q16};
      FC_I: val_nxt = sneg ? 17'(-$signed({1'b0, q16})) : {1'b0, q16};
      FC_ERR, FC_CS_C, FC_AC_I, FC_CS_I, FC_MODE: val_nxt = {9'd0, u[7:0]};
      FC_WARN, FC_AR: val_nxt = {9'd0, pack_mask(u[15:0])};
      default: val_nxt = {1'b0, u[15:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      code_r <= q_line.code;
      val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (q_ready) vld_r <= q_valid;
  end
endmodule

// ===== rtl/label_value_line_parser_top.sv =====
// Top level of the label/value line parser.
// Depends on lvlp_pkg, lvlp_front, lvlp_queue and lvlp_back.

// The parser takes one byte of a "label<TAB>value<LF>" text stream per
// transfer and accepts one byte every cycle while its line queue has room.
// The front end keeps up to eight label characters and scans the value like
// strtoul/strtol; at LF it matches the label against the table chosen by the
// device kind register and queues the line. The back end converts the value
// for the matched field and holds it in the output register, so a result
// appears only after the line has passed through the queue. Unknown labels
// produce no result. The rate is set by the two-entry queue: while the output
// is stalled, bytes keep flowing until one matched line sits in the output
// register and two more wait in the queue; from then on every byte waits.
// Write the device kind only while the parser is idle.
module label_value_line_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_device_kind,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_field_code,
  output logic signed [16:0] out_field_value
);
  import lvlp_pkg::*;

  logic  kind_r;
  logic  fq_valid, fq_ready, qb_valid, qb_ready;
  line_t fq_line, qb_line;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= 1'b0;
    else if (cfg_valid) kind_r <= cfg_device_kind;
  end

  lvlp_front u_front (
    .clk, .rst_n, .device_kind(kind_r), .in_valid, .in_ready, .in_data_byte,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_line(fq_line)
  );

  lvlp_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_line(fq_line),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_line(qb_line)
  );

  lvlp_back u_back (
    .clk, .rst_n, .q_valid(qb_valid), .q_ready(qb_ready), .q_line(qb_line),
    .out_valid, .out_ready, .out_field_code, .out_field_value
  );
endmodule
